FILE: design/rllc_pkg.sv
package rllc_pkg;

   localparam int PIXEL_W     = 8;
   localparam int THRESH_W    = 8;
   localparam int DIM_W       = 11;
   localparam int ROW_INDEX_W = 10;
   localparam int CENTROID_W  = 18;
   localparam int FRAC_BITS   = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd2;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd128;
   localparam logic [DIM_W-1:0]    ROW_WIDTH_RESET = 11'd640;
   localparam logic [DIM_W-1:0]    ROW_COUNT_RESET = 11'd480;

   typedef struct packed {
      logic pixel_ready;
      logic take_pixel;
      logic start_div;
      logic div_step;
      logic load_out;
   } rllc_cmd_type;

   typedef struct packed {
      logic row_end;
      logic div_last;
      logic out_free;
   } rllc_status_type;

endpackage

FILE: design/rllc_ifs.sv
interface rllc_pixel_if;
   import rllc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface rllc_result_if;
   import rllc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ROW_INDEX_W-1:0] row_index;
   logic [CENTROID_W-1:0]  centroid_column;
   logic                   row_dark;
   logic                   frame_last;

   modport source (output valid, output row_index, output centroid_column,
                   output row_dark, output frame_last, input ready);
   modport sink (input valid, input row_index, input centroid_column,
                 input row_dark, input frame_last, output ready);
endinterface

interface rllc_csr_if;
   import rllc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/rllc_datapath.sv
module rllc_datapath #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_ROWS  = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rllc_pkg::rllc_cmd_type           cmd,
   output rllc_pkg::rllc_status_type        status,
   input  logic [rllc_pkg::PIXEL_W-1:0]     pixel_value,
   input  logic                             csr_write,
   input  logic [rllc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rllc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rllc_pkg::ROW_INDEX_W-1:0] rsp_row_index,
   output logic [rllc_pkg::CENTROID_W-1:0]  rsp_centroid_column,
   output logic                             rsp_row_dark,
   output logic                             rsp_frame_last
);
   import rllc_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SW    = CW + PIXEL_W;          // mass sum
   localparam int MW    = 2 * CW + PIXEL_W;      // moment sum
   localparam int PW    = CW + PIXEL_W;          // column * pixel
   localparam int QW    = CW + FRAC_BITS;        // quotient bits
   localparam int CNT_W = $clog2(QW + 1);
   localparam int MAXD  = (CW > RW) ? CW : RW;
   localparam int CMP_W = ((MAXD > DIM_W) ? MAXD : DIM_W) + 2;

   logic [THRESH_W-1:0] threshold_ff;
   logic [DIM_W-1:0]    row_width_ff;
   logic [DIM_W-1:0]    row_count_ff;

   logic [CW-1:0]       col_ff;
   logic [RW-1:0]       row_ff;
   logic [SW-1:0]       mass_ff;
   logic [MW-1:0]       moment_ff;

   logic [SW-1:0]       rem_ff;
   logic [QW-1:0]       quo_ff;
   logic [SW-1:0]       divisor_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                dark_ff;
   logic                last_ff;
   logic [RW-1:0]       row_idx_ff;

   logic                   out_valid_ff;
   logic [ROW_INDEX_W-1:0] out_row_ff;
   logic [CENTROID_W-1:0]  out_cent_ff;
   logic                   out_dark_ff;
   logic                   out_last_ff;

   logic [CMP_W-1:0]    width_eff;
   logic [CMP_W-1:0]    rows_eff;
   logic                row_end;
   logic                frame_end;
   logic [PIXEL_W-1:0]  gated;
   logic [PW-1:0]       prod;
   logic [SW-1:0]       mass_in;
   logic [MW-1:0]       moment_in;
   logic [SW:0]         trial;
   logic [SW:0]         diff;
   logic                fits;
   logic [RW+ROW_INDEX_W-1:0] row_wide;
   logic [QW+CENTROID_W-1:0]  cent_wide;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         row_width_ff <= ROW_WIDTH_RESET;
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[THRESH_W-1:0];
            CSR_ROW_WIDTH: row_width_ff <= csr_data[DIM_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp dimensions into 1..max
   always_comb begin
      if (row_width_ff == '0) width_eff = CMP_W'(1);
      else if (CMP_W'(row_width_ff) > CMP_W'(MAX_WIDTH)) width_eff = CMP_W'(MAX_WIDTH);
      else width_eff = CMP_W'(row_width_ff);

      if (row_count_ff == '0) rows_eff = CMP_W'(1);
      else if (CMP_W'(row_count_ff) > CMP_W'(MAX_ROWS)) rows_eff = CMP_W'(MAX_ROWS);
      else rows_eff = CMP_W'(row_count_ff);
   end

   assign row_end   = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;
   assign frame_end = (CMP_W'(row_ff) + CMP_W'(1)) >= rows_eff;

   assign gated     = (pixel_value > threshold_ff) ? pixel_value : '0;
   assign prod      = PW'(col_ff) * PW'(gated);
   assign mass_in   = mass_ff + SW'(gated);
   assign moment_in = moment_ff + MW'(prod);

   // row accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         mass_ff   <= '0;
         moment_ff <= '0;
      end else if (cmd.take_pixel) begin
         if (row_end) begin
            col_ff    <= '0;
            mass_ff   <= '0;
            moment_ff <= '0;
            row_ff    <= frame_end ? '0 : row_ff + RW'(1);
         end else begin
            col_ff    <= col_ff + CW'(1);
            mass_ff   <= mass_in;
            moment_ff <= moment_in;
         end
      end
   end

   // restoring divider, one quotient bit per step
   // the high part of moment*256 is below the mass, so QW steps suffice
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start_div) begin
         cnt_ff <= CNT_W'(QW);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         rem_ff     <= moment_in[MW-1:CW];
         quo_ff     <= {moment_in[CW-1:0], {FRAC_BITS{1'b0}}};
         divisor_ff <= mass_in;
         dark_ff    <= (mass_in == '0);
         last_ff    <= frame_end;
         row_idx_ff <= row_ff;
      end else if (cmd.div_step) begin
         rem_ff <= fits ? diff[SW-1:0] : trial[SW-1:0];
         quo_ff <= {quo_ff[QW-2:0], fits};
      end
   end

   // output register
   assign row_wide  = {{ROW_INDEX_W{1'b0}}, row_idx_ff};
   assign cent_wide = {{CENTROID_W{1'b0}}, quo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_row_ff  <= row_wide[ROW_INDEX_W-1:0];
         out_cent_ff <= dark_ff ? '0 : cent_wide[CENTROID_W-1:0];
         out_dark_ff <= dark_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_row_index       = out_row_ff;
   assign rsp_centroid_column = out_cent_ff;
   assign rsp_row_dark        = out_dark_ff;
   assign rsp_frame_last      = out_last_ff;

   assign status.row_end  = row_end;
   assign status.div_last = (cnt_ff == CNT_W'(1));
   assign status.out_free = !out_valid_ff || rsp_ready;

endmodule

FILE: design/rllc_controller.sv
module rllc_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  rllc_pkg::rllc_status_type status,
   output rllc_pkg::rllc_cmd_type    cmd
);
   import rllc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      // a row end waits while the divider still holds the previous row
      cmd.pixel_ready = (state_ff == ST_IDLE) || !status.row_end;
      cmd.take_pixel  = req_valid && cmd.pixel_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take_pixel && status.row_end) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: design/row_laser_line_centroid.sv
// Row centroid of a laser line image. Monochrome pixels come in raster order, one per
// clock while ready is high; a pixel above the threshold counts with its value, any other
// as zero. After the last pixel of a row one transaction gives the row's intensity
// centroid as column * 256 (8 fraction bits, truncated), with row_dark set and the
// centroid zero when no pixel was lit, and frame_last on the frame's last row. The
// quotient comes from a restoring divider that forms one bit per cycle, and the result
// is then loaded into the output register once that register is free. Pixels of the
// next row are taken while the divider runs; only a row's last pixel waits for the
// divider to hand over, so it stalls while the previous row's result is not yet loaded.
// The user must write registers through the csr channel only while no row is in flight;
// the block itself does not enforce this. They take effect on the next pixel.
module row_laser_line_centroid #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_ROWS  = 1024
) (
   input logic          clock,
   input logic          reset,
   rllc_pixel_if.sink   req_chan,
   rllc_result_if.source rsp_chan,
   rllc_csr_if.sink     csr_chan
);
   import rllc_pkg::*;

   rllc_cmd_type    cmd;
   rllc_status_type status;

   assign req_chan.ready = cmd.pixel_ready;
   assign csr_chan.ready = 1'b1;

   rllc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   rllc_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .pixel_value         (req_chan.pixel_value),
      .csr_write           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_row_index       (rsp_chan.row_index),
      .rsp_centroid_column (rsp_chan.centroid_column),
      .rsp_row_dark        (rsp_chan.row_dark),
      .rsp_frame_last      (rsp_chan.frame_last)
   );

endmodule

FILE: design/rllc_checker.sv
module rllc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [rllc_pkg::ROW_INDEX_W-1:0] rsp_row_index,
   input logic [rllc_pkg::CENTROID_W-1:0]  rsp_centroid_column,
   input logic                             rsp_row_dark,
   input logic                             rsp_frame_last
);
   import rllc_pkg::*;

   logic [ROW_INDEX_W-1:0] row_expect_ff;

   // row that the next result must carry
   always_ff @(posedge clock) begin
      if (reset) begin
         row_expect_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         row_expect_ff <= rsp_frame_last ? '0 : rsp_row_index + ROW_INDEX_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_centroid_column) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_dark |-> rsp_centroid_column == '0)
      else $error("dark row with nonzero centroid");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_index == row_expect_ff)
      else $error("row index out of sequence");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind row_laser_line_centroid rllc_checker u_rllc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_row_index       (rsp_chan.row_index),
   .rsp_centroid_column (rsp_chan.centroid_column),
   .rsp_row_dark        (rsp_chan.row_dark),
   .rsp_frame_last      (rsp_chan.frame_last)
);
